[rtl/core/psv_pkg.sv]
package psv_pkg;

	localparam int unsigned FIELD_W = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_DIV,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_value;
		logic read_cell;
		logic div_start;
		logic div_step;
		logic next_cell;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic step_last;
		logic divisible;
		logic chain_full;
	} status_t;

endpackage

[rtl/core/psv_ram.sv]
module psv_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/psv_datapath.sv]
module psv_datapath #(
	parameter int unsigned NUM_CELLS    = 16,
	parameter int unsigned NUMBER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  psv_pkg::cmd_t                   cmd,
	output psv_pkg::status_t                status,
	input  logic [psv_pkg::FIELD_W-1:0]     candidate,
	output logic [psv_pkg::FIELD_W-1:0]     found_value,
	output logic                            chain_full
);

	localparam int unsigned NW = NUMBER_WIDTH;
	localparam int unsigned FW = psv_pkg::FIELD_W;
	localparam int unsigned CW = $clog2(NUM_CELLS + 1);
	localparam int unsigned AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int unsigned SW = $clog2(NW);

	logic [NW+FW-1:0] cand_ext;
	logic [NW+FW-1:0] value_ext;
	logic [NW-1:0]    value_q;
	logic [NW-1:0]    cell_rdata;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    dvd_q;
	logic [NW-1:0]    div_q;
	logic [SW-1:0]    step_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    filled_q;
	logic [NW:0]      trial;
	logic [NW:0]      diff;
	logic             fits;
	logic             is_full;
	logic             store_en;
	logic [FW-1:0]    found_q;
	logic             full_q;

	assign cand_ext  = {{NW{1'b0}}, candidate};
	assign value_ext = {{FW{1'b0}}, value_q};

	// one restoring step per cycle
	assign trial = {rem_q, dvd_q[NW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	assign is_full  = filled_q == CW'(NUM_CELLS);
	assign store_en = cmd.commit && !is_full;

	assign status.scan_done  = idx_q == filled_q;
	assign status.step_last  = step_q == SW'(NW - 1);
	assign status.divisible  = rem_q == '0;
	assign status.chain_full = is_full;

	psv_ram #(
		.WIDTH (NW),
		.DEPTH (NUM_CELLS)
	) u_cells (
		.clk     (clk),
		.we      (store_en),
		.waddr   (filled_q[AW-1:0]),
		.wdata   (value_q),
		.re      (cmd.read_cell),
		.raddr   (idx_q[AW-1:0]),
		.rdata_q (cell_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.load_value) begin
				idx_q <= '0;
			end else if (cmd.next_cell) begin
				idx_q <= idx_q + 1'b1;
			end
			if (store_en) begin
				filled_q <= filled_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_value) begin
			value_q <= cand_ext[NW-1:0];
		end
		if (cmd.div_start) begin
			div_q  <= cell_rdata;
			dvd_q  <= value_q;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= fits ? diff[NW-1:0] : trial[NW-1:0];
			dvd_q  <= {dvd_q[NW-2:0], 1'b0};
			step_q <= step_q + 1'b1;
		end
		if (cmd.commit) begin
			found_q <= value_ext[FW-1:0];
			full_q  <= is_full;
		end
	end

	assign found_value = found_q;
	assign chain_full  = full_q;

endmodule

[rtl/core/psv_ctrl.sv]
module psv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output psv_pkg::cmd_t     cmd,
	input  psv_pkg::status_t  status
);

	psv_pkg::state_t state_q;
	psv_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psv_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			psv_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_value = 1'b1;
					state_d        = psv_pkg::ST_SCAN;
				end
			end
			psv_pkg::ST_SCAN: begin
				if (status.scan_done) begin
					state_d = psv_pkg::ST_EMIT;
				end else begin
					cmd.read_cell = 1'b1;
					state_d       = psv_pkg::ST_LOAD;
				end
			end
			psv_pkg::ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = psv_pkg::ST_DIV;
			end
			psv_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.step_last) begin
					state_d = psv_pkg::ST_CHECK;
				end
			end
			psv_pkg::ST_CHECK: begin
				// a zero cell leaves the value as remainder, so it divides only zero
				if (status.divisible) begin
					state_d = psv_pkg::ST_IDLE;
				end else begin
					cmd.next_cell = 1'b1;
					state_d       = psv_pkg::ST_SCAN;
				end
			end
			psv_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = psv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = psv_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/pipelined_prime_sieve.sv]
// channel   handshake             payload
// input     in_valid / in_stall   candidate
// output    out_valid / out_stall found_value, chain_full
//
// an item is tested against each stored prime in turn by the bit-serial remainder
// unit, one quotient bit a cycle
// a dropped item ends at the first stored prime that divides it
// reset clears the fill count; cell contents are only read once written
// the next item is taken while a result waits under out_stall
module pipelined_prime_sieve #(
	parameter int unsigned NUM_CELLS    = 16,
	parameter int unsigned NUMBER_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [psv_pkg::FIELD_W-1:0] candidate,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [psv_pkg::FIELD_W-1:0] found_value,
	output logic                        chain_full
);

	psv_pkg::cmd_t    cmd;
	psv_pkg::status_t status;

	psv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	psv_datapath #(
		.NUM_CELLS    (NUM_CELLS),
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.candidate   (candidate),
		.found_value (found_value),
		.chain_full  (chain_full)
	);

endmodule

[rtl/core/psv_checker.sv]
module psv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [psv_pkg::FIELD_W-1:0] candidate,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [psv_pkg::FIELD_W-1:0] found_value,
	input logic                        chain_full
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found_value) && $stable(chain_full))
		else $error("stalled result changed");

	// a held input item keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(candidate))
		else $error("stalled input item changed");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result came out the cycle after accept");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("block not idle after issuing a result");

endmodule

bind pipelined_prime_sieve psv_checker u_psv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.candidate   (candidate),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found_value (found_value),
	.chain_full  (chain_full)
);

[tb/sv/pipelined_prime_sieve_test.sv]
module pipelined_prime_sieve_test;

	localparam int unsigned CELLS = 16;
	localparam int unsigned RANDOM_ITEMS = 550;
	localparam int unsigned PAUSE_ITEM = 300;
	localparam int unsigned CALM_FIRST = 400;
	localparam int unsigned CALM_LAST = 450;
	localparam int unsigned LONG_HOLD_AT = 30;
	localparam int unsigned LONG_HOLD_CYCLES = 1500;
	localparam int unsigned TAIL_CYCLES = 400;

	typedef logic [psv_pkg::FIELD_W-1:0] number_t;

	typedef struct packed {
		number_t value;
		logic    full;
	} found_t;

	// has: a result is expected; full: its chain_full flag; value equals the candidate
	typedef struct packed {
		number_t cand;
		bit      typed;
		bit      has;
		bit      full;
	} sieve_row_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	number_t candidate = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	number_t found_value;
	logic    chain_full;

	number_t     prime_cells[CELLS];
	int unsigned cells_filled;
	found_t      pending_found[$];
	int unsigned error_count;
	int unsigned received;
	int unsigned stall_left;
	bit          long_hold_done;

	sieve_row_t directed_rows[25] = '{
		'{16'd0, 1'b1, 1'b1, 1'b0},
		'{16'd0, 1'b1, 1'b0, 1'b0},
		'{16'd2, 1'b1, 1'b1, 1'b0},
		'{16'd65535, 1'b0, 1'b0, 1'b0},
		'{16'd65534, 1'b1, 1'b0, 1'b0},
		'{16'd2, 1'b1, 1'b0, 1'b0},
		'{16'd3, 1'b0, 1'b0, 1'b0},
		'{16'd9, 1'b0, 1'b0, 1'b0},
		'{16'd65521, 1'b0, 1'b0, 1'b0},
		'{16'd5, 1'b0, 1'b0, 1'b0},
		'{16'd7, 1'b0, 1'b0, 1'b0},
		'{16'd11, 1'b0, 1'b0, 1'b0},
		'{16'd13, 1'b0, 1'b0, 1'b0},
		'{16'd17, 1'b0, 1'b0, 1'b0},
		'{16'd19, 1'b0, 1'b0, 1'b0},
		'{16'd23, 1'b0, 1'b0, 1'b0},
		'{16'd29, 1'b0, 1'b0, 1'b0},
		'{16'd31, 1'b0, 1'b0, 1'b0},
		'{16'd37, 1'b0, 1'b0, 1'b0},
		'{16'd41, 1'b0, 1'b0, 1'b0},
		'{16'd43, 1'b0, 1'b0, 1'b0},
		'{16'd1, 1'b0, 1'b0, 1'b0},
		'{16'd32768, 1'b1, 1'b0, 1'b0},
		'{16'd85, 1'b0, 1'b0, 1'b0},
		'{16'd2491, 1'b0, 1'b0, 1'b0}
	};

	pipelined_prime_sieve #(
		.NUM_CELLS   (CELLS),
		.NUMBER_WIDTH(psv_pkg::FIELD_W)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.candidate  (candidate),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found_value(found_value),
		.chain_full (chain_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// a stored zero divides only zero
	function automatic bit sieve_survivor(input number_t value, output bit full);
		for (int i = 0; i < cells_filled; i++) begin
			if (prime_cells[i] == '0 ? value == '0 : value % prime_cells[i] == '0)
				return 1'b0;
		end
		full = (cells_filled == CELLS);
		if (!full) begin
			prime_cells[cells_filled] = value;
			cells_filled++;
		end
		return 1'b1;
	endfunction

	task automatic offer_candidate(input number_t value, input bit drain, input bit calm,
			input bit typed, input bit typed_has, input bit typed_full);
		int gap;
		bit survives;
		bit full;
		gap = calm ? 0 : idle_length();
		if (drain) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (pending_found.size() != 0);
		end else if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		candidate <= value;
		do @(posedge clk); while (in_stall !== 1'b0);
		survives = sieve_survivor(value, full);
		if (typed) begin
			survives = typed_has;
			full = typed_full;
		end
		if (survives)
			pending_found.push_back('{value: value, full: full});
	endtask

	// result side: check, then pick the next stall
	initial begin
		found_t exp_item;
		received = 0;
		stall_left = 0;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				received++;
				if (pending_found.size() == 0) begin
					$error("item with no expectation: found_value %0d chain_full %0b",
						found_value, chain_full);
					error_count++;
				end else begin
					exp_item = pending_found.pop_front();
					if (found_value !== exp_item.value) begin
						$error("found_value: expected %0d, actual %0d",
							exp_item.value, found_value);
						error_count++;
					end
					if (chain_full !== exp_item.full) begin
						$error("chain_full: expected %0b, actual %0b",
							exp_item.full, chain_full);
						error_count++;
					end
				end
			end
			if (!long_hold_done && received == LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = (received >= 70 && received < 90) ? 0 : idle_length();
			end
		end
	end

	initial begin
		int unsigned sent;
		int unsigned run_len;
		int pick;
		number_t run_value;
		number_t run_step;
		error_count = 0;
		cells_filled = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_candidate(directed_rows[i].cand, 1'b0, 1'b0, directed_rows[i].typed,
				directed_rows[i].has, directed_rows[i].full);

		// mostly ascending runs, some noise and descending runs
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			run_value = number_t'($urandom_range(0, 65535));
			run_step = number_t'(1);
			run_len = 1;
			if (pick < 7) begin
				run_len = $urandom_range(4, 24);
				run_step = $urandom_range(0, 1) ? number_t'(1) : number_t'(2);
			end else if (pick == 8) begin
				case ($urandom_range(0, 3))
					0: run_value = '0;
					1: run_value = number_t'(1);
					2: run_value = '1;
					default: run_value = number_t'(16'hFFFE);
				endcase
			end else if (pick == 9) begin
				run_len = $urandom_range(4, 12);
				run_step = '1;
			end
			for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
				offer_candidate(run_value, sent == PAUSE_ITEM,
					sent >= CALM_FIRST && sent < CALM_LAST, 1'b0, 1'b0, 1'b0);
				run_value += run_step;
				sent++;
			end
		end

		in_valid <= 1'b0;
		while (pending_found.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
